// ----- hw/rtl/pprv_pkg.sv -----
// Shared types and constants for the PPU register port.
package pprv_pkg;

    localparam int unsigned ADDR_W     = 15;
    localparam int unsigned VRAM_AW    = 14;
    localparam int unsigned PATTERN_AW = 13;
    localparam int unsigned NT_AW      = 11;
    localparam int unsigned PAL_AW     = 5;
    localparam int unsigned OAM_AW     = 8;

    localparam logic [5:0] PAL_PAGE = 6'h3f;

    typedef enum logic [1:0] {
        OP_READ      = 2'd0,
        OP_WRITE     = 2'd1,
        OP_VBL_BEGIN = 2'd2,
        OP_VBL_END   = 2'd3
    } opcode_t;

    localparam logic [2:0] REG_CTRL     = 3'd0;
    localparam logic [2:0] REG_MASK     = 3'd1;
    localparam logic [2:0] REG_STATUS   = 3'd2;
    localparam logic [2:0] REG_OAM_ADDR = 3'd3;
    localparam logic [2:0] REG_OAM_DATA = 3'd4;
    localparam logic [2:0] REG_SCROLL   = 3'd5;
    localparam logic [2:0] REG_ADDR     = 3'd6;
    localparam logic [2:0] REG_DATA     = 3'd7;

    localparam logic [1:0] MIRROR_VERT  = 2'd0;
    localparam logic [1:0] MIRROR_HORIZ = 2'd1;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_EXEC = 1'b1
    } state_t;

    typedef struct packed {
        logic [1:0] opcode;
        logic [2:0] reg_select;
        logic [7:0] write_data;
    } in_word_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic       nmi_request;
    } out_word_t;

endpackage

// ----- hw/rtl/pprv_oam.sv -----
// Sprite attribute memory, one write and one registered read port.
module pprv_oam (
    input  logic                       clk,
    input  logic [pprv_pkg::OAM_AW-1:0] addr,
    input  logic                       we,
    input  logic [7:0]                 wdata,
    output logic [7:0]                 rdata
);
    import pprv_pkg::*;

    logic [7:0] mem [2**OAM_AW];
    logic [7:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- hw/rtl/pprv_vram.sv -----
// Video memory map: pattern, mirrored nametable and palette memories.
module pprv_vram (
    input  logic                        clk,
    input  logic [pprv_pkg::ADDR_W-1:0] addr,
    input  logic [1:0]                  mirror_mode,
    input  logic                        we,
    input  logic [7:0]                  wdata,
    output logic [7:0]                  rdata
);
    import pprv_pkg::*;

    logic [7:0] pattern_mem [2**PATTERN_AW];
    logic [7:0] nt_mem      [2**NT_AW];
    logic [7:0] pal_mem     [2**PAL_AW];

    logic [VRAM_AW-1:0] a;
    logic               is_pattern;
    logic               is_pal;
    logic               nt_mapped;
    logic               nt_table;
    logic [NT_AW-1:0]   nt_idx;
    logic [PAL_AW-1:0]  pal_idx;

    logic [7:0] pattern_q_reg;
    logic [7:0] nt_q_reg;
    logic [7:0] pal_q_reg;
    logic       is_pattern_reg;
    logic       is_pal_reg;
    logic       nt_mapped_reg;

    always_comb
    begin
        a          = addr[VRAM_AW-1:0];
        is_pattern = ~a[VRAM_AW-1];
        is_pal     = (a[VRAM_AW-1:8] == PAL_PAGE);
        nt_mapped  = (mirror_mode == MIRROR_VERT) || (mirror_mode == MIRROR_HORIZ);
        nt_table   = (mirror_mode == MIRROR_VERT) ? a[10] : a[11];
        nt_idx     = {nt_table, a[9:0]};
        pal_idx    = a[PAL_AW-1:0];
        // mirrors of the backdrop entries in the sprite half
        if (pal_idx[4] && (pal_idx[1:0] == 2'b00))
        begin
            pal_idx[4] = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (we && is_pattern)
        begin
            pattern_mem[a[PATTERN_AW-1:0]] <= wdata;
        end
        if (we && !is_pattern && !is_pal && nt_mapped)
        begin
            nt_mem[nt_idx] <= wdata;
        end
        if (we && is_pal)
        begin
            pal_mem[pal_idx] <= wdata;
        end
        pattern_q_reg  <= pattern_mem[a[PATTERN_AW-1:0]];
        nt_q_reg       <= nt_mem[nt_idx];
        pal_q_reg      <= pal_mem[pal_idx];
        is_pattern_reg <= is_pattern;
        is_pal_reg     <= is_pal;
        nt_mapped_reg  <= nt_mapped;
    end

    always_comb
    begin
        if (is_pattern_reg)
        begin
            rdata = pattern_q_reg;
        end
        else if (is_pal_reg)
        begin
            rdata = pal_q_reg;
        end
        else if (nt_mapped_reg)
        begin
            rdata = nt_q_reg;
        end
        else
        begin
            rdata = 8'h00;
        end
    end

endmodule

// ----- hw/rtl/ppu_register_port_vram_access_core.sv -----
// PPU CPU-facing register port with scroll/address registers and video memories.
// Usage:
//   A command word (opcode, reg_select, write_data) is taken at a rising edge
//   where start is high and busy is low. Opcodes: register read, register
//   write, vblank begin, vblank end.
//   Each command yields one result word (read_data, nmi_request), shown on
//   result for exactly one cycle with done high; the receiver cannot stall.
//   done rises at the edge that ends the execute state, and the receiver
//   takes the result word while done is high. No new command is taken
//   while busy is high in the execute state. The video and sprite memories
//   are synchronous with registered read ports; the memory is read at
//   the accepting edge and updated in the following execute cycle, during
//   which busy is high, so back-to-back accesses never overlap.
//   cfg_we/cfg_data write the nametable mirroring mode; write only when idle.
//   Reset clears all registers but item_reg and result_reg; returns to idle.
//   Memories are not cleared; a location must be written before it is read.
module ppu_register_port_vram_access_core (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  pprv_pkg::in_word_t   item,
    output logic                 done,
    output pprv_pkg::out_word_t  result,
    input  logic                 cfg_we,
    input  logic [1:0]           cfg_data
);
    import pprv_pkg::*;

    state_t state_reg, state_next;

    in_word_t item_reg;

    logic [1:0]        mirror_reg;
    logic [7:0]        control_reg, control_next;
    logic [7:0]        mask_reg, mask_next;
    logic              vblank_reg, vblank_next;
    logic              toggle_reg, toggle_next;
    logic [2:0]        fine_x_reg, fine_x_next;
    logic [ADDR_W-1:0] temp_reg, temp_next;
    logic [ADDR_W-1:0] cur_reg, cur_next;
    logic [7:0]        buffer_reg, buffer_next;
    logic [OAM_AW-1:0] oam_idx_reg, oam_idx_next;

    logic      done_reg, done_next;
    out_word_t result_reg, result_next;

    logic       exec;
    logic       vram_we;
    logic       oam_we;
    logic [7:0] vram_rdata;
    logic [7:0] oam_rdata;
    logic [ADDR_W-1:0] step;
    logic       cur_is_pal;
    logic [7:0] d;

    pprv_vram u_vram (
        .clk         (clk),
        .addr        (cur_reg),
        .mirror_mode (mirror_reg),
        .we          (vram_we),
        .wdata       (item_reg.write_data),
        .rdata       (vram_rdata)
    );

    pprv_oam u_oam (
        .clk   (clk),
        .addr  (oam_idx_reg),
        .we    (oam_we),
        .wdata (item_reg.write_data),
        .rdata (oam_rdata)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        busy = 1'b0;
        exec = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                busy = 1'b0;
                exec = 1'b0;
            end
            ST_EXEC:
            begin
                busy = 1'b1;
                exec = 1'b1;
            end
            default:
            begin
                busy = 1'b0;
                exec = 1'b0;
            end
        endcase
    end

    assign vram_we = exec && (item_reg.opcode == OP_WRITE) && (item_reg.reg_select == REG_DATA);
    assign oam_we  = exec && (item_reg.opcode == OP_WRITE)
                     && (item_reg.reg_select == REG_OAM_DATA);

    always_comb
    begin
        d            = item_reg.write_data;
        step         = control_reg[2] ? ADDR_W'(32) : ADDR_W'(1);
        cur_is_pal   = (cur_reg[VRAM_AW-1:8] == PAL_PAGE);
        control_next = control_reg;
        mask_next    = mask_reg;
        vblank_next  = vblank_reg;
        toggle_next  = toggle_reg;
        fine_x_next  = fine_x_reg;
        temp_next    = temp_reg;
        cur_next     = cur_reg;
        buffer_next  = buffer_reg;
        oam_idx_next = oam_idx_reg;
        done_next    = exec;
        result_next  = '0;
        if (exec)
        begin
            case (item_reg.opcode)
                OP_READ:
                begin
                    case (item_reg.reg_select)
                        REG_STATUS:
                        begin
                            result_next.read_data = {vblank_reg, 7'b0};
                            vblank_next = 1'b0;
                            toggle_next = 1'b0;
                        end
                        REG_OAM_DATA:
                        begin
                            result_next.read_data = oam_rdata;
                        end
                        REG_DATA:
                        begin
                            // palette reads skip the buffer delay
                            result_next.read_data = cur_is_pal ? vram_rdata : buffer_reg;
                            buffer_next = vram_rdata;
                            cur_next    = cur_reg + step;
                        end
                        default:
                        begin
                        end
                    endcase
                end
                OP_WRITE:
                begin
                    case (item_reg.reg_select)
                        REG_CTRL:
                        begin
                            control_next = d;
                            temp_next    = {temp_reg[14:12], d[1:0], temp_reg[9:0]};
                        end
                        REG_MASK:
                        begin
                            mask_next = d;
                        end
                        REG_OAM_ADDR:
                        begin
                            oam_idx_next = d;
                        end
                        REG_OAM_DATA:
                        begin
                            oam_idx_next = oam_idx_reg + OAM_AW'(1);
                        end
                        REG_SCROLL:
                        begin
                            if (toggle_reg)
                            begin
                                temp_next = {d[2:0], temp_reg[11:10], d[7:3], temp_reg[4:0]};
                            end
                            else
                            begin
                                fine_x_next = d[2:0];
                                temp_next   = {temp_reg[14:5], d[7:3]};
                            end
                            toggle_next = ~toggle_reg;
                        end
                        REG_ADDR:
                        begin
                            if (toggle_reg)
                            begin
                                temp_next = {temp_reg[14:8], d};
                                cur_next  = {temp_reg[14:8], d};
                            end
                            else
                            begin
                                temp_next = {1'b0, d[5:0], temp_reg[7:0]};
                            end
                            toggle_next = ~toggle_reg;
                        end
                        REG_DATA:
                        begin
                            cur_next = cur_reg + step;
                        end
                        default:
                        begin
                        end
                    endcase
                end
                OP_VBL_BEGIN:
                begin
                    vblank_next = 1'b1;
                    result_next.nmi_request = control_reg[7];
                end
                OP_VBL_END:
                begin
                    vblank_next = 1'b0;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            mirror_reg  <= '0;
            control_reg <= '0;
            mask_reg    <= '0;
            vblank_reg  <= 1'b0;
            toggle_reg  <= 1'b0;
            fine_x_reg  <= '0;
            temp_reg    <= '0;
            cur_reg     <= '0;
            buffer_reg  <= '0;
            oam_idx_reg <= '0;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            if (cfg_we)
            begin
                mirror_reg <= cfg_data;
            end
            control_reg <= control_next;
            mask_reg    <= mask_next;
            vblank_reg  <= vblank_next;
            toggle_reg  <= toggle_next;
            fine_x_reg  <= fine_x_next;
            temp_reg    <= temp_next;
            cur_reg     <= cur_next;
            buffer_reg  <= buffer_next;
            oam_idx_reg <= oam_idx_next;
            done_reg    <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            item_reg <= item;
        end
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

    a_done_after_exec: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg == ST_EXEC))
        else $error("done without an execute cycle");

    a_exec_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EXEC) |=> (state_reg == ST_IDLE) && done)
        else $error("execute phase did not complete in one cycle");

    a_nmi_only_on_done: assert property (@(posedge clk) disable iff (!rst_n)
        (result.nmi_request && done) |-> $past(control_reg[7]))
        else $error("nmi request without nmi enable");

endmodule
